>>> rtl/core/bellman_ford_shortest_path_unit_macros.svh
// Assertion macros shared by the shortest path unit.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef BELLMAN_FORD_SHORTEST_PATH_UNIT_MACROS_SVH
`define BELLMAN_FORD_SHORTEST_PATH_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/bfsp_pkg.sv
package bfsp_pkg;

  // Fixed field widths of the channels.
  localparam int VTX_W          = 6;
  localparam int WEIGHT_FIELD_W = 16;
  localparam int DIST_W         = 32;
  localparam int NV_W           = 7;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 7;

  // Saturation limits of the distance arithmetic.
  localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_VERTEX = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [NV_W-1:0]  VERTEX_COUNT_RST  = 7'd64;
  localparam logic [VTX_W-1:0] SOURCE_VERTEX_RST = 6'd0;

  // One edge on the input channel.
  typedef struct packed {
    logic [VTX_W-1:0]                 edge_from;
    logic [VTX_W-1:0]                 edge_to;
    logic signed [WEIGHT_FIELD_W-1:0] edge_weight;
    logic                             last_edge;
  } edge_item_t;

  // One vertex result on the output channel.
  typedef struct packed {
    logic [VTX_W-1:0]         vertex_index;
    logic signed [DIST_W-1:0] distance;
    logic                     reachable;
    logic                     negative_cycle;
    logic                     last_result;
  } result_item_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_EDGE_RD,
    ST_U_RD,
    ST_V_RD,
    ST_RELAX,
    ST_OUT_RD,
    ST_OUT_LOAD,
    ST_OUT_WAIT
  } bfsp_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_edge;
    logic init;
    logic rd_edge;
    logic rd_u;
    logic rd_v;
    logic relax;
    logic k_clr;
    logic k_inc;
    logic pass_inc;
    logic v_clr;
    logic v_inc;
    logic out_rd;
    logic out_load;
    logic finish;
  } bfsp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic edge_last;
    logic final_pass;
    logic hit;
    logic vtx_last;
    logic out_done;
  } bfsp_status_t;

endpackage

>>> rtl/core/bfsp_ram.sv
module bfsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/bfsp_ctrl.sv
module bfsp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_last,
  output logic                  in_stall,
  output bfsp_pkg::bfsp_cmd_t    cmd,
  input  bfsp_pkg::bfsp_status_t status
);

  import bfsp_pkg::*;

  bfsp_state_t state_r;
  bfsp_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Edges are taken only while the block is loading.
  assign in_stall = (state_r != ST_LOAD);

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          cmd.load_edge = 1'b1;
          if (in_last) begin
            state_nxt = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        cmd.k_clr = 1'b1;
        state_nxt = ST_EDGE_RD;
      end
      ST_EDGE_RD: begin
        cmd.rd_edge = 1'b1;
        state_nxt   = ST_U_RD;
      end
      ST_U_RD: begin
        cmd.rd_u  = 1'b1;
        state_nxt = ST_V_RD;
      end
      ST_V_RD: begin
        cmd.rd_v  = 1'b1;
        state_nxt = ST_RELAX;
      end
      ST_RELAX: begin
        cmd.relax = 1'b1;
        if (status.final_pass && status.hit) begin
          // A cycle is proven; the rest of the check pass cannot change it.
          cmd.v_clr = 1'b1;
          state_nxt = ST_OUT_RD;
        end else if (status.edge_last) begin
          cmd.k_clr = 1'b1;
          if (status.final_pass) begin
            cmd.v_clr = 1'b1;
            state_nxt = ST_OUT_RD;
          end else begin
            cmd.pass_inc = 1'b1;
            state_nxt    = ST_EDGE_RD;
          end
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = ST_EDGE_RD;
        end
      end
      ST_OUT_RD: begin
        cmd.out_rd = 1'b1;
        state_nxt  = ST_OUT_LOAD;
      end
      ST_OUT_LOAD: begin
        cmd.out_load = 1'b1;
        state_nxt    = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (status.out_done) begin
          if (status.vtx_last) begin
            cmd.finish = 1'b1;
            state_nxt  = ST_LOAD;
          end else begin
            cmd.v_inc = 1'b1;
            state_nxt = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

>>> rtl/core/bfsp_dp.sv
module bfsp_dp #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 1024,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bfsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bfsp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  bfsp_pkg::edge_item_t                in_data,
  input  logic                                out_stall,
  output logic                                out_valid,
  output bfsp_pkg::result_item_t              out_data,
  input  bfsp_pkg::bfsp_cmd_t                 cmd,
  output bfsp_pkg::bfsp_status_t              status
);

  import bfsp_pkg::*;

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW  = $clog2(MAX_EDGES + 1);
  localparam int EW  = 2 * VTX_W + WEIGHT_BITS;

  // Configuration registers.
  logic [NV_W-1:0]  vcount_r;
  logic [VTX_W-1:0] src_r;

  // Run state.
  logic [NV_W-1:0]         nv_r;
  logic [CW-1:0]           total_r;
  logic [EAW-1:0]          k_r;
  logic [NV_W-1:0]         pass_r;
  logic [VW-1:0]           vidx_r;
  logic [MAX_VERTICES-1:0] reach_r;
  logic [MAX_VERTICES-1:0] reach_nxt;
  logic                    cycle_r;
  logic signed [DIST_W-1:0] du_r;
  logic                    out_valid_r;
  result_item_t            out_data_r;

  logic [NV_W-1:0]          nv_clamp;
  logic [DIST_W-1:0]        wfield_ext;
  logic [WEIGHT_BITS-1:0]   wt_in;
  logic [EW-1:0]            edge_wdata;
  logic [EW-1:0]            edge_rdata;
  logic                     edge_we;
  logic [VTX_W-1:0]         e_from;
  logic [VTX_W-1:0]         e_to;
  logic [WEIGHT_BITS-1:0]   e_wt;
  logic signed [DIST_W-1:0] wt32;
  logic [DIST_W:0]          sum;
  logic signed [DIST_W-1:0] sat_sum;
  logic signed [DIST_W-1:0] dist_rdata;
  logic [DIST_W-1:0]        dist_rraw;
  logic                     dist_we;
  logic [VW-1:0]            dist_waddr;
  logic [DIST_W-1:0]        dist_wdata;
  logic                     dist_re;
  logic [VW-1:0]            dist_raddr;
  logic                     edge_ok;
  logic                     hit;
  logic                     full;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VERTEX_COUNT_RST;
      src_r    <= SOURCE_VERTEX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VERTEX_COUNT:  vcount_r <= cfg_data;
        CFG_SOURCE_VERTEX: src_r    <= cfg_data[VTX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Vertex count limited to the range the block supports.
  always_comb begin
    if (vcount_r == '0) begin
      nv_clamp = NV_W'(1);
    end else if (vcount_r > NV_W'(MAX_VERTICES)) begin
      nv_clamp = NV_W'(MAX_VERTICES);
    end else begin
      nv_clamp = vcount_r;
    end
  end

  // The weight sign sits at bit WEIGHT_BITS-1 of the zero-extended field.
  assign wfield_ext = DIST_W'(unsigned'(in_data.edge_weight));
  assign wt_in      = wfield_ext[WEIGHT_BITS-1:0];
  assign edge_wdata = {in_data.edge_from, in_data.edge_to, wt_in};
  assign full       = (total_r == CW'(MAX_EDGES));
  assign edge_we    = cmd.load_edge && !full;

  // Edge list storage.
  bfsp_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (total_r[EAW-1:0]),
    .wdata (edge_wdata),
    .re    (cmd.rd_edge),
    .raddr (k_r),
    .rdata (edge_rdata)
  );

  assign e_from = edge_rdata[EW-1 -: VTX_W];
  assign e_to   = edge_rdata[EW-VTX_W-1 -: VTX_W];
  assign e_wt   = edge_rdata[WEIGHT_BITS-1:0];

  // Distance storage: source written at start, end vertices during relaxation.
  always_comb begin
    dist_re    = cmd.rd_u || cmd.rd_v || cmd.out_rd;
    dist_raddr = vidx_r;
    if (cmd.rd_u) begin
      dist_raddr = e_from[VW-1:0];
    end else if (cmd.rd_v) begin
      dist_raddr = e_to[VW-1:0];
    end
    if (cmd.init) begin
      dist_we    = (NV_W'(src_r) < nv_clamp);
      dist_waddr = src_r[VW-1:0];
      dist_wdata = '0;
    end else begin
      dist_we    = cmd.relax && hit && !status.final_pass;
      dist_waddr = e_to[VW-1:0];
      dist_wdata = sat_sum;
    end
  end

  bfsp_ram #(
    .WIDTH (DIST_W),
    .DEPTH (MAX_VERTICES)
  ) u_dist_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .re    (dist_re),
    .raddr (dist_raddr),
    .rdata (dist_rraw)
  );

  assign dist_rdata = signed'(dist_rraw);

  // Saturating sum of the start distance and the edge weight.
  always_comb begin
    wt32 = signed'({{(DIST_W-WEIGHT_BITS){e_wt[WEIGHT_BITS-1]}}, e_wt});
    sum  = {du_r[DIST_W-1], du_r} + {wt32[DIST_W-1], wt32};
    case (sum[DIST_W:DIST_W-1])
      2'b01:   sat_sum = DIST_MAX;
      2'b10:   sat_sum = DIST_MIN;
      default: sat_sum = signed'(sum[DIST_W-1:0]);
    endcase
  end

  // Relaxation test; the end distance is on the RAM output in this cycle.
  assign edge_ok = (NV_W'(e_from) < nv_r) && (NV_W'(e_to) < nv_r)
                   && reach_r[e_from[VW-1:0]];
  assign hit     = edge_ok && (!reach_r[e_to[VW-1:0]] || (sat_sum < dist_rdata));

  // Reach flags for the next cycle.
  always_comb begin
    reach_nxt = reach_r;
    if (cmd.init) begin
      reach_nxt = '0;
      if (NV_W'(src_r) < nv_clamp) begin
        reach_nxt[src_r[VW-1:0]] = 1'b1;
      end
    end else if (dist_we) begin
      reach_nxt[e_to[VW-1:0]] = 1'b1;
    end
  end

  // Control registers of a run.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      k_r         <= '0;
      pass_r      <= NV_W'(1);
      vidx_r      <= '0;
      nv_r        <= NV_W'(1);
      reach_r     <= '0;
      cycle_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      reach_r <= reach_nxt;
      if (edge_we) begin
        total_r <= total_r + CW'(1);
      end else if (cmd.finish) begin
        total_r <= '0;
      end
      if (cmd.init) begin
        nv_r    <= nv_clamp;
        pass_r  <= NV_W'(1);
        cycle_r <= 1'b0;
      end else if (cmd.pass_inc) begin
        pass_r <= pass_r + NV_W'(1);
      end
      if (cmd.relax && hit && status.final_pass) begin
        cycle_r <= 1'b1;
      end
      if (cmd.k_clr) begin
        k_r <= '0;
      end else if (cmd.k_inc) begin
        k_r <= k_r + EAW'(1);
      end
      if (cmd.v_clr) begin
        vidx_r <= '0;
      end else if (cmd.v_inc) begin
        vidx_r <= vidx_r + VW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (status.out_done) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Start distance and output payload registers.
  always_ff @(posedge clk) begin
    if (cmd.rd_v) begin
      du_r <= dist_rdata;
    end
    if (cmd.out_load) begin
      out_data_r.vertex_index   <= VTX_W'(vidx_r);
      out_data_r.distance       <= reach_r[vidx_r] ? dist_rdata : '0;
      out_data_r.reachable      <= reach_r[vidx_r];
      out_data_r.negative_cycle <= cycle_r;
      out_data_r.last_result    <= (NV_W'(vidx_r) == nv_r - NV_W'(1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status back to the controller.
  assign status.edge_last  = (CW'(k_r) == total_r - CW'(1));
  assign status.final_pass = (pass_r == nv_r);
  assign status.hit        = hit;
  assign status.vtx_last   = (NV_W'(vidx_r) == nv_r - NV_W'(1));
  assign status.out_done   = out_valid_r && !out_stall;

endmodule

>>> rtl/core/bellman_ford_shortest_path_unit.sv
// Single-source shortest path engine over a directed, weighted edge list.
// Input channel (in_valid, in_stall, in_data): one edge per transfer; one
// edge is taken per cycle while the block is loading. The transfer with
// last_edge set is stored too and starts the computation; in_stall stays high
// from then until the last result has been transferred.
// Configuration (cfg_we, cfg_index, cfg_data): vertex count and source vertex,
// written while the block is idle.
// Computation: an initialisation step, then nv passes over the E stored edges,
// each edge handled as edge memory read, start distance read, end distance
// read, then compare and write-back on the single distance memory port; the
// last pass is a check pass and ends early when it finds a negative cycle.
// Output channel (out_valid, out_stall, out_data): nv results, vertex 0 first;
// each is read, loaded and held until taken while out_stall is low, and
// the held result does not change while stalled.
// Reset clears the edge list, sets vertex count to 64 and source to 0; the
// distance memory needs no clearing pass.
`include "bellman_ford_shortest_path_unit_macros.svh"

module bellman_ford_shortest_path_unit #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 1024,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bfsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bfsp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  bfsp_pkg::edge_item_t            in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output bfsp_pkg::result_item_t          out_data
);

  import bfsp_pkg::*;

  bfsp_cmd_t    cmd;
  bfsp_status_t status;

  // Sequencer.
  bfsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_edge),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  // Storage, arithmetic and output register.
  bfsp_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

  // No edge is taken while results are pending.
  `BFSP_ASSERT_NOW(a_no_load_during_output, out_valid, in_stall,
    "edge input open while a result is pending")

  // A last edge starts the computation and closes the input.
  `BFSP_ASSERT_NEXT(a_last_edge_starts, in_valid && !in_stall && in_data.last_edge,
    in_stall, "input still open after the last edge")

  // The final result returns the block to loading.
  `BFSP_ASSERT_NEXT(a_last_result_reopens, out_valid && !out_stall && out_data.last_result,
    !in_stall && !out_valid, "block not idle after the final result")

  // An unreachable vertex reports distance zero.
  `BFSP_ASSERT_NOW(a_unreachable_zero, out_valid && !out_data.reachable,
    out_data.distance == '0, "unreachable vertex with a nonzero distance")

endmodule
